// ----- hw/rtl/b62e_pkg.sv -----
// Package for the base62 escape bit encoder.
// Holds the request and result payload types and shared constants; no dependencies.
package b62e_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    logic [5:0] symbol;
    logic       run_end;
  } out_item_t;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;
  localparam int unsigned QueueCntW  = 2;

  localparam logic [5:0] Radix      = 6'd62;
  localparam logic [3:0] GroupBits  = 4'd6;
  localparam logic [3:0] EscapeBits = 4'd5;
  localparam logic [1:0] MaxSymbols = 2'd3;

endpackage

// ----- hw/rtl/b62e_queue.sv -----
// Front of the encoder: accepts byte requests into a short queue.
// Depends on b62e_pkg for the request type and queue depth.
module b62e_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  b62e_pkg::in_item_t   in_data_i,
  output logic                 pop_valid_o,
  input  logic                 pop_ready_i,
  output b62e_pkg::in_item_t   pop_data_o
);
  import b62e_pkg::*;

  in_item_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0]   cnt_q;
  logic                   push, pop;

  assign in_ready_o  = (cnt_q != QueueCntW'(QueueDepth));
  assign pop_valid_o = (cnt_q != '0);
  assign pop_data_o  = mem_q[rd_ptr_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + QueuePtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + QueuePtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + QueueCntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - QueueCntW'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/b62e_back.sv -----
// Back of the encoder: merges queued bytes into the bit buffer and emits
// one base62 symbol per cycle, while the output register is free, into that register. Depends on b62e_pkg.
module b62e_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 pop_valid_i,
  output logic                 pop_ready_o,
  input  b62e_pkg::in_item_t   pop_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b62e_pkg::out_item_t  out_data_o
);
  import b62e_pkg::*;

  typedef enum logic {StLoad, StEmit} state_e;

  state_e      state_q;
  logic [14:0] buf_q;
  logic [3:0]  fill_q;
  logic        cp_q, cv_q, last_q;
  logic [1:0]  cnt_q;
  logic        ovalid_q;
  out_item_t   out_q;

  logic [3:0]  need, rem, nneed;
  logic [14:0] shifted, mask;
  logic [5:0]  v, sym;
  logic        can_take, wrap, esc, last_sym, out_free, emit;

  always_comb begin
    need     = cp_q ? EscapeBits : GroupBits;
    can_take = (fill_q >= need) && (cnt_q != MaxSymbols);
    rem      = fill_q - need;
    shifted  = buf_q >> rem;
    v        = cp_q ? {shifted[4:0], cv_q} : shifted[5:0];
    wrap     = (v >= Radix);
    sym      = wrap ? (v - Radix) : v;
    esc      = (sym <= 6'd1);
    nneed    = esc ? EscapeBits : GroupBits;
    last_sym = (rem < nneed) || (cnt_q == MaxSymbols - 2'd1);
    mask     = (15'd1 << rem) - 15'd1;
    out_free = !ovalid_q || out_ready_i;
    emit     = (state_q == StEmit) && can_take && out_free;
  end

  assign pop_ready_o = (state_q == StLoad);
  assign out_valid_o = ovalid_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StLoad;
      buf_q    <= '0;
      fill_q   <= '0;
      cp_q     <= 1'b0;
      cv_q     <= 1'b0;
      last_q   <= 1'b0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
      out_q    <= '0;
    end else begin
      if (emit) begin
        ovalid_q <= 1'b1;
      end else if (out_ready_i) begin
        ovalid_q <= 1'b0;
      end
      unique case (state_q)
        StLoad: begin
          if (pop_valid_i) begin
            buf_q   <= {buf_q[6:0], pop_data_i.data_byte};
            fill_q  <= fill_q + 4'd8;
            last_q  <= pop_data_i.final_byte;
            cnt_q   <= '0;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (!can_take) begin
            state_q <= StLoad;
            if (last_q) begin
              buf_q  <= '0;
              fill_q <= '0;
              cp_q   <= 1'b0;
              cv_q   <= 1'b0;
            end
          end else if (out_free) begin
            out_q.symbol  <= sym;
            out_q.run_end <= last_sym;
            cnt_q         <= cnt_q + 2'd1;
            if (last_sym) begin
              state_q <= StLoad;
            end
            if (last_sym && last_q) begin
              buf_q  <= '0;
              fill_q <= '0;
              cp_q   <= 1'b0;
              cv_q   <= 1'b0;
            end else begin
              buf_q  <= buf_q & mask;
              fill_q <= rem;
              cp_q   <= esc;
              cv_q   <= esc & wrap;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

endmodule

// ----- hw/rtl/base62_escape_bit_encoder_core.sv -----
// Base62 escape bit encoder, top level.
// Instantiates b62e_queue (front) and b62e_back (symbol engine); uses b62e_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one byte per request,
//   most significant bit first; final_byte marks the end of a stream.
//   Output channel (out_valid_o/out_ready_i/out_data_o) returns base62 symbol
//   indexes 0..61; run_end flags the last symbol caused by a byte.
//   A byte that completes no 6-bit (or 5-bit escape) group gives no symbol.
// With the back end idle, a request passes the queue, the buffer load in StLoad
//   and the StEmit step into the output register before its first symbol is out.
// Each byte is loaded in StLoad, then its symbols are emitted in StEmit by the
//   single group extractor in the back end, one symbol a cycle while the output
//   register is free; the back end takes no new byte until it is back in StLoad.
// A two-entry request queue lets the front keep accepting while the back
//   end works or the receiver stalls; when the output register is held,
//   extraction pauses and the queue fills, then in_ready_o drops.
// Reset clears the queue, the bit buffer, its fill count and the escape
//   carry. After a final byte the leftover bits and any carry are dropped.
module base62_escape_bit_encoder_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  b62e_pkg::in_item_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output b62e_pkg::out_item_t  out_data_o
);
  import b62e_pkg::*;

  logic     pop_valid, pop_ready;
  in_item_t pop_data;

  b62e_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  b62e_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_data_i  (pop_data),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
